### sv/variable_rate_sample_player_macros.svh
// Assertion helpers shared by the player RTL.
// Each macro expects clk and rst to be in scope at the place of use.
`ifndef VARIABLE_RATE_SAMPLE_PLAYER_MACROS_SVH
`define VARIABLE_RATE_SAMPLE_PLAYER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define VRSP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("vrsp assertion failed");

// Next-cycle implication, checked outside reset.
`define VRSP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("vrsp assertion failed");

`endif

### sv/vrsp_pkg.sv
`default_nettype none

package vrsp_pkg;

  // Store geometry and position format
  localparam int ADDR_BITS = 16;
  localparam int FRAC_BITS = 16;
  localparam int DEPTH     = 1 << ADDR_BITS;
  localparam int CNT_W     = ADDR_BITS + 1;
  localparam int POS_W     = ADDR_BITS + 1 + FRAC_BITS;
  localparam int DEN_W     = CNT_W + FRAC_BITS;
  localparam int IDX_W     = POS_W + 1 - FRAC_BITS;

  // Item fields
  localparam int KIND_W   = 3;
  localparam int SADDR_W  = 16;
  localparam int SAMPLE_W = 16;
  localparam int AUDIO_W  = 16;
  localparam int PROG_W   = 16;

  // Registers
  localparam int COUNT_REG_W = 17;
  localparam int SPEED_W     = 19;
  localparam int GAIN_W      = 16;
  localparam int GAIN_FRAC   = 12;
  localparam int CFG_DATA_W  = 19;
  localparam int CFG_IDX_W   = 2;

  // Position arithmetic widths
  localparam int SUM_W  = ((POS_W > SPEED_W) ? POS_W : SPEED_W) + 1;
  localparam int NXT_W  = SUM_W + 1;
  localparam int RND_W  = NXT_W - FRAC_BITS;
  localparam int PROD_W = SAMPLE_W + GAIN_W + 1;
  localparam int GSH_W  = PROD_W + 1 - GAIN_FRAC;
  localparam int STEP_W = $clog2(PROG_W + 1);

  localparam logic [KIND_W-1:0] KIND_TICK  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_WRITE = 3'd1;
  localparam logic [KIND_W-1:0] KIND_PLAY  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_PAUSE = 3'd3;
  localparam logic [KIND_W-1:0] KIND_STOP  = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED        = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LOOP         = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN         = 2'd3;

  localparam logic [SPEED_W-1:0] SPEED_RESET = 19'd65536;
  localparam logic [GAIN_W-1:0]  GAIN_RESET  = 16'd4096;

  // Progress divider result
  typedef struct packed {
    logic              done;
    logic [PROG_W-1:0] quotient;
  } div_result_t;

endpackage

`default_nettype wire

### sv/vrsp_if.sv
`default_nettype none

// Command item channel
interface vrsp_item_if;
  logic                                  valid;
  logic                                  ready;
  logic        [vrsp_pkg::KIND_W-1:0]    kind;
  logic        [vrsp_pkg::SADDR_W-1:0]   sample_address;
  logic signed [vrsp_pkg::SAMPLE_W-1:0]  sample_value;

  modport source (output valid, kind, sample_address, sample_value, input ready);
  modport sink   (input valid, kind, sample_address, sample_value, output ready);
endinterface

// Audio result channel
interface vrsp_result_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [vrsp_pkg::AUDIO_W-1:0]  audio_out;
  logic        [vrsp_pkg::PROG_W-1:0]   progress;
  logic                                 playing;

  modport source (output valid, audio_out, progress, playing, input ready);
  modport sink   (input valid, audio_out, progress, playing, output ready);
endinterface

`default_nettype wire

### sv/vrsp_ram.sv
`default_nettype none

// Simple dual-port RAM, registered read data
module vrsp_ram #(
  parameter int ADDR_W = 16,
  parameter int DATA_W = 16
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [DATA_W-1:0] wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [(1 << ADDR_W)];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### sv/vrsp_div.sv
`default_nettype none

// Progress divider: floor(pos * 2^16 / (count << FRAC_BITS)), one bit a cycle
module vrsp_div (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic [vrsp_pkg::POS_W-1:0]  pos,
  input  wire logic [vrsp_pkg::CNT_W-1:0]  count,
  output vrsp_pkg::div_result_t            result
);

  logic [vrsp_pkg::DEN_W-1:0]  den;
  logic [vrsp_pkg::DEN_W-1:0]  rem;
  logic [vrsp_pkg::PROG_W-1:0] quo;
  logic [vrsp_pkg::STEP_W-1:0] steps;
  logic                        busy;
  logic                        done;
  logic [vrsp_pkg::DEN_W-1:0]  den_start;
  logic [vrsp_pkg::DEN_W:0]    rem2;
  logic                        fits;

  assign den_start = {count, {vrsp_pkg::FRAC_BITS{1'b0}}};
  assign rem2      = {rem, 1'b0};
  assign fits      = rem2 >= {1'b0, den};

  // Control: start, iterate, signal done
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        if (count == '0 || vrsp_pkg::DEN_W'(pos) >= den_start) begin
          done <= 1'b1;
        end else begin
          busy <= 1'b1;
        end
      end else if (busy && steps == vrsp_pkg::STEP_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // Datapath: restoring division with a running remainder
  always_ff @(posedge clk) begin
    if (start) begin
      den   <= den_start;
      rem   <= vrsp_pkg::DEN_W'(pos);
      steps <= vrsp_pkg::STEP_W'(vrsp_pkg::PROG_W);
      if (count == '0) begin
        quo <= '0;
      end else if (vrsp_pkg::DEN_W'(pos) >= den_start) begin
        quo <= '1;
      end else begin
        quo <= '0;
      end
    end else if (busy) begin
      rem   <= fits ? vrsp_pkg::DEN_W'(rem2 - {1'b0, den}) : vrsp_pkg::DEN_W'(rem2);
      quo   <= {quo[vrsp_pkg::PROG_W-2:0], fits};
      steps <= steps - vrsp_pkg::STEP_W'(1);
    end
  end

  assign result.done     = done;
  assign result.quotient = quo;

endmodule

`default_nettype wire

### sv/variable_rate_sample_player.sv
// Variable-rate sample player.
// Items arrive on item_in (valid/ready): kind 1 writes sample_value into the
// sample store at sample_address, kinds 2/3/4 play, pause and stop (stop also
// rewinds), kind 0 is a tick that makes one result on result_out. Other kinds
// are taken and dropped. Registers are written through cfg_we/cfg_index/
// cfg_data; the user must do so only while idle, the block does not enforce it.
// Writes and controls complete at accept. A tick's store read is issued at
// accept, the next cycle updates the position, applies the gain and starts
// the progress divider, the bit-serial divider then runs, the quotient is
// registered when it is done, and the output register is loaded once it is
// free. With a zero count or a position at or past the end the divider
// finishes without iterating. item_in.ready is high only while idle, so no
// new item is taken until a tick's result has been loaded into the output
// register.
// The output register holds a finished result while the receiver stalls;
// the next item is still taken, and a later tick waits at its last step
// until the held result is taken.
// Reset (rst, synchronous) pauses playback, rewinds to position 0 and loads
// the register defaults; the store is not cleared, entries are written first.
`default_nettype none

`include "variable_rate_sample_player_macros.svh"

module variable_rate_sample_player (
  input  wire logic                                clk,
  input  wire logic                                rst,
  vrsp_item_if.sink                                item_in,
  vrsp_result_if.source                            result_out,
  input  wire logic                                cfg_we,
  input  wire logic [vrsp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [vrsp_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_ADV  = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  logic [vrsp_pkg::COUNT_REG_W-1:0] sample_count;
  logic [vrsp_pkg::SPEED_W-1:0]     speed;
  logic                             loop_enable;
  logic [vrsp_pkg::GAIN_W-1:0]      gain;

  logic [vrsp_pkg::POS_W-1:0]       pos;
  logic                             playing;
  logic [vrsp_pkg::SUM_W-1:0]       pos_sum;
  logic                             tick_play;
  logic                             rd_ok;
  logic signed [vrsp_pkg::PROD_W-1:0] prod;

  logic [vrsp_pkg::CNT_W-1:0]       eff_count;
  logic                             accept;
  logic                             tick_acc;
  logic [vrsp_pkg::POS_W:0]         idx_full;
  logic [vrsp_pkg::IDX_W-1:0]       idx;
  logic                             rd_hit;
  logic [vrsp_pkg::SAMPLE_W-1:0]    ram_q;
  logic signed [vrsp_pkg::SAMPLE_W-1:0] sample;
  logic [vrsp_pkg::NXT_W-1:0]       rn_full;
  logic [vrsp_pkg::RND_W-1:0]       rn;
  logic                             wrap;
  logic [vrsp_pkg::POS_W-1:0]       pos_upd;
  logic [vrsp_pkg::POS_W-1:0]       div_pos;
  vrsp_pkg::div_result_t            div_res;
  logic signed [vrsp_pkg::PROD_W:0] prod_rnd;
  logic signed [vrsp_pkg::GSH_W-1:0] gained;
  logic signed [vrsp_pkg::AUDIO_W-1:0] audio_sat;
  logic                             out_free;
  logic [vrsp_pkg::PROG_W-1:0]      progress_q;

  // Count clipped to the store depth
  assign eff_count = (32'(sample_count) > 32'(vrsp_pkg::DEPTH))
                   ? vrsp_pkg::CNT_W'(vrsp_pkg::DEPTH)
                   : vrsp_pkg::CNT_W'(sample_count);

  assign item_in.ready = (state == S_IDLE);
  assign accept        = item_in.valid && item_in.ready;
  assign tick_acc      = accept && item_in.kind == vrsp_pkg::KIND_TICK;
  assign out_free      = !result_out.valid || result_out.ready;

  // Rounded read index of the current position
  assign idx_full = (vrsp_pkg::POS_W + 1)'(pos)
                  + (vrsp_pkg::POS_W + 1)'(1 << (vrsp_pkg::FRAC_BITS - 1));
  assign idx      = idx_full[vrsp_pkg::POS_W:vrsp_pkg::FRAC_BITS];
  assign rd_hit   = playing && idx < vrsp_pkg::IDX_W'(eff_count);

  // Sample store
  vrsp_ram #(
    .ADDR_W (vrsp_pkg::ADDR_BITS),
    .DATA_W (vrsp_pkg::SAMPLE_W)
  ) u_store (
    .clk   (clk),
    .we    (accept && item_in.kind == vrsp_pkg::KIND_WRITE),
    .waddr (vrsp_pkg::ADDR_BITS'(item_in.sample_address)),
    .wdata (item_in.sample_value),
    .re    (tick_acc),
    .raddr (idx[vrsp_pkg::ADDR_BITS-1:0]),
    .rdata (ram_q)
  );

  // Advance: wrap when the rounded next position reaches the count
  assign rn_full = vrsp_pkg::NXT_W'(pos_sum)
                 + vrsp_pkg::NXT_W'(1 << (vrsp_pkg::FRAC_BITS - 1));
  assign rn      = rn_full[vrsp_pkg::NXT_W-1:vrsp_pkg::FRAC_BITS];
  assign wrap    = rn >= vrsp_pkg::RND_W'(eff_count);
  assign pos_upd = wrap ? '0 : pos_sum[vrsp_pkg::POS_W-1:0];
  assign div_pos = tick_play ? pos_upd : pos;
  // rd_ok is only set on a playing tick, so a paused tick sees sample 0
  assign sample  = rd_ok ? $signed(ram_q) : '0;

  // Progress divider
  vrsp_div u_div (
    .clk    (clk),
    .rst    (rst),
    .start  (state == S_ADV),
    .pos    (div_pos),
    .count  (eff_count),
    .result (div_res)
  );

  // Gain rounding (half up) and saturation
  assign prod_rnd = (vrsp_pkg::PROD_W + 1)'(prod)
                  + (vrsp_pkg::PROD_W + 1)'(1 << (vrsp_pkg::GAIN_FRAC - 1));
  assign gained   = vrsp_pkg::GSH_W'(prod_rnd >>> vrsp_pkg::GAIN_FRAC);
  always_comb begin
    if (gained > vrsp_pkg::GSH_W'(32767)) begin
      audio_sat = 16'sh7FFF;
    end else if (gained < -vrsp_pkg::GSH_W'(32768)) begin
      audio_sat = 16'sh8000;
    end else begin
      audio_sat = vrsp_pkg::AUDIO_W'(gained);
    end
  end

  // Sequencer
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (tick_acc) state_next = S_ADV;
      S_ADV:  state_next = S_DIV;
      S_DIV:  if (div_res.done) state_next = S_OUT;
      S_OUT:  if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count <= '0;
      speed        <= vrsp_pkg::SPEED_RESET;
      loop_enable  <= 1'b0;
      gain         <= vrsp_pkg::GAIN_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        vrsp_pkg::REG_SAMPLE_COUNT: sample_count <= vrsp_pkg::COUNT_REG_W'(cfg_data);
        vrsp_pkg::REG_SPEED:        speed        <= vrsp_pkg::SPEED_W'(cfg_data);
        vrsp_pkg::REG_LOOP:         loop_enable  <= cfg_data[0];
        vrsp_pkg::REG_GAIN:         gain         <= vrsp_pkg::GAIN_W'(cfg_data);
        default: ;
      endcase
    end
  end

  // Play state and position
  always_ff @(posedge clk) begin
    if (rst) begin
      playing <= 1'b0;
      pos     <= '0;
    end else if (accept) begin
      case (item_in.kind)
        vrsp_pkg::KIND_PLAY:  playing <= 1'b1;
        vrsp_pkg::KIND_PAUSE: playing <= 1'b0;
        vrsp_pkg::KIND_STOP: begin
          playing <= 1'b0;
          pos     <= '0;
        end
        default: ;
      endcase
    end else if (state == S_ADV && tick_play) begin
      pos <= pos_upd;
      if (wrap && !loop_enable) begin
        playing <= 1'b0;
      end
    end
  end

  // Tick pipeline registers
  always_ff @(posedge clk) begin
    if (tick_acc) begin
      tick_play <= playing;
      rd_ok     <= rd_hit;
      pos_sum   <= vrsp_pkg::SUM_W'(pos) + vrsp_pkg::SUM_W'(speed);
    end
    if (state == S_ADV) begin
      prod <= vrsp_pkg::PROD_W'(sample) * vrsp_pkg::PROD_W'($signed({1'b0, gain}));
    end
    if (state == S_DIV && div_res.done) begin
      progress_q <= div_res.quotient;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_out.valid <= 1'b0;
    end else if (state == S_OUT && out_free) begin
      result_out.valid <= 1'b1;
    end else if (result_out.ready) begin
      result_out.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_OUT && out_free) begin
      result_out.audio_out <= audio_sat;
      result_out.progress  <= progress_q;
      result_out.playing   <= playing;
    end
  end

  `VRSP_ASSERT_NEXT(a_tick_starts, tick_acc, state == S_ADV)
  `VRSP_ASSERT_NOW(a_div_done_in_wait, div_res.done, state == S_DIV)
  `VRSP_ASSERT_NEXT(a_pos_in_range, state == S_ADV && tick_play,
    pos == '0 || pos[vrsp_pkg::POS_W-1:vrsp_pkg::FRAC_BITS] < eff_count)
  `VRSP_ASSERT_NEXT(a_out_held, state == S_OUT && !out_free, state == S_OUT)

endmodule

`default_nettype wire
